// ===== sv/height_to_normal_map_pixel_top_assert.svh =====
// ----------------------------------------------------------------------------
// Height-to-normal-map pixel assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_NORMAL_MAP_PIXEL_TOP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HNM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hnm assertion failed");

// Next-cycle implication, checked outside reset.
`define HNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hnm assertion failed");

`endif

// ===== sv/hnm_pkg.sv =====
// ----------------------------------------------------------------------------
// hnm_pkg
// Types and fixed constants of the height-to-normal-map pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hnm_pkg;

  // Fixed widths after magnitude normalisation.
  localparam int WidthBits = 13;
  localparam int NormBits  = 29;
  localparam int SqBits    = 2 * NormBits;
  localparam int SumBits   = 60;
  localparam int RootBits  = 30;
  localparam int NumBits   = RootBits + 1;
  localparam int ProdBits  = NumBits + 8;
  localparam int DivSteps  = 8;

  // Configuration register indexes.
  localparam logic CFG_WATER_LEVEL   = 1'b0;
  localparam logic CFG_TEXTURE_WIDTH = 1'b1;

  // Reset values and the flat water normal.
  localparam logic [15:0] WATER_LEVEL_RST   = 16'd0;
  localparam logic [12:0] TEXTURE_WIDTH_RST = 13'd1024;
  localparam logic [7:0]  WATER_RED         = 8'd128;
  localparam logic [7:0]  WATER_GREEN       = 8'd128;
  localparam logic [7:0]  WATER_BLUE        = 8'd255;
  localparam logic [7:0]  ENC_SCALE         = 8'd255;

  // Normalised vector travelling with an item.
  typedef struct packed {
    logic                land;
    logic                nx;
    logic                ny;
    logic [NormBits-1:0] mx;
    logic [NormBits-1:0] my;
    logic [NormBits-1:0] mz;
  } hnm_vec_t;

  // Square root stage contents: remainder and partial root.
  typedef struct packed {
    hnm_vec_t            vec;
    logic [SumBits-1:0]  rem;
    logic [RootBits-1:0] root;
  } hnm_sqrt_t;

  // Division stage contents for the three lanes.
  typedef struct packed {
    logic                     land;
    logic [2:0][ProdBits-1:0] rem;
    logic [2:0][7:0]          quo;
    logic [NumBits-1:0]       den;
  } hnm_div_t;

endpackage

`default_nettype wire

// ===== sv/height_to_normal_map_pixel_top.sv =====
// ----------------------------------------------------------------------------
// Height-to-normal-map pixel
// Turns a height and its right and lower neighbours into an RGB normal.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o| center, right, below heights
//  out     | out_valid_o/out_stall_i| is_land, normal red, green, blue
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item enters per cycle while the output is not stalled; the stages are five front stages, one
// stage per root bit of the 30-bit square root, one encode stage and one
// stage per quotient bit of the 8-bit divider lanes.
// The whole pipeline holds while a result waits and the output is stalled.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module height_to_normal_map_pixel_top import hnm_pkg::*; #(
  parameter int HEIGHT_BITS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire signed [HEIGHT_BITS-1:0]  center_height_i,
  input  wire signed [HEIGHT_BITS-1:0]  right_height_i,
  input  wire signed [HEIGHT_BITS-1:0]  below_height_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          is_land_o,
  output logic [7:0]                    normal_red_o,
  output logic [7:0]                    normal_green_o,
  output logic [7:0]                    normal_blue_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire                           cfg_index_i,
  input  wire [15:0]                    cfg_data_i
);

  localparam int FracBits  = HEIGHT_BITS - 2;
  localparam int MagBits   = HEIGHT_BITS + WidthBits;
  localparam int ExtBits   = (MagBits > NormBits) ? MagBits : NormBits;
  localparam int ShiftBits = $clog2(ExtBits + 1);
  localparam int CmpBits   = (HEIGHT_BITS > 16) ? HEIGHT_BITS : 16;

  logic en;

  // Configuration registers.
  logic signed [15:0] water_level_q;
  logic [12:0]        texture_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_level_q   <= WATER_LEVEL_RST;
      texture_width_q <= TEXTURE_WIDTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WATER_LEVEL:   water_level_q   <= cfg_data_i;
        CFG_TEXTURE_WIDTH: texture_width_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished item is held.
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: land test, differences and their magnitudes.
  logic signed [CmpBits-1:0]   c_ext, wl_ext;
  logic signed [HEIGHT_BITS:0] dx, dy, adx_full, ady_full;
  logic                        s1_v_q, s1_land_q, s1_nx_q, s1_ny_q;
  logic [HEIGHT_BITS-1:0]      s1_adx_q, s1_ady_q;

  always_comb begin
    c_ext    = CmpBits'(center_height_i);
    wl_ext   = CmpBits'(water_level_q);
    dx       = (HEIGHT_BITS+1)'(right_height_i) - (HEIGHT_BITS+1)'(center_height_i);
    dy       = (HEIGHT_BITS+1)'(below_height_i) - (HEIGHT_BITS+1)'(center_height_i);
    adx_full = dx[HEIGHT_BITS] ? -dx : dx;
    ady_full = dy[HEIGHT_BITS] ? -dy : dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_land_q <= c_ext > wl_ext;
      s1_nx_q   <= !dx[HEIGHT_BITS] && (dx != '0);
      s1_ny_q   <= dy[HEIGHT_BITS];
      s1_adx_q  <= adx_full[HEIGHT_BITS-1:0];
      s1_ady_q  <= ady_full[HEIGHT_BITS-1:0];
    end
  end

  // Stage 2: scale by the texture width and half width.
  logic                s2_v_q, s2_land_q, s2_nx_q, s2_ny_q;
  logic [MagBits-1:0]  s2_mx_q, s2_my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_land_q <= s1_land_q;
      s2_nx_q   <= s1_nx_q;
      s2_ny_q   <= s1_ny_q;
      s2_mx_q   <= MagBits'(s1_adx_q) * MagBits'(texture_width_q);
      s2_my_q   <= MagBits'(s1_ady_q) * MagBits'(texture_width_q >> 1);
    end
  end

  // Stage 3: shift all magnitudes right until each fits the norm width.
  logic [ExtBits-1:0]   mx_ext, my_ext, mz_ext, mag_or, mx_sh, my_sh, mz_sh;
  logic [ShiftBits-1:0] norm_shift;
  logic                 s3_v_q;
  hnm_vec_t             s3_q;

  always_comb begin
    mx_ext     = ExtBits'(s2_mx_q);
    my_ext     = ExtBits'(s2_my_q);
    mz_ext     = ExtBits'(1) << FracBits;
    mag_or     = mx_ext | my_ext | mz_ext;
    norm_shift = '0;
    for (int i = NormBits; i < ExtBits; i++) begin
      if (mag_or[i]) begin
        norm_shift = ShiftBits'(i - NormBits + 1);
      end
    end
    mx_sh = mx_ext >> norm_shift;
    my_sh = my_ext >> norm_shift;
    mz_sh = mz_ext >> norm_shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.land <= s2_land_q;
      s3_q.nx   <= s2_nx_q;
      s3_q.ny   <= s2_ny_q;
      s3_q.mx   <= mx_sh[NormBits-1:0];
      s3_q.my   <= my_sh[NormBits-1:0];
      s3_q.mz   <= mz_sh[NormBits-1:0];
    end
  end

  // Stage 4: squares of the three components.
  logic              s4_v_q;
  hnm_vec_t          s4_vec_q;
  logic [SqBits-1:0] s4_sx_q, s4_sy_q, s4_sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_vec_q <= s3_q;
      s4_sx_q  <= SqBits'(s3_q.mx) * SqBits'(s3_q.mx);
      s4_sy_q  <= SqBits'(s3_q.my) * SqBits'(s3_q.my);
      s4_sz_q  <= SqBits'(s3_q.mz) * SqBits'(s3_q.mz);
    end
  end

  // Stage 5 and square root stages: entry 0 holds the sum of squares,
  // each following entry has resolved one more root bit, top bit first.
  logic [RootBits:0] sq_v_q;
  hnm_sqrt_t         sq_q [RootBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
    end else if (en) begin
      sq_v_q <= {sq_v_q[RootBits-1:0], s4_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].vec  <= s4_vec_q;
      sq_q[0].rem  <= SumBits'(s4_sx_q) + SumBits'(s4_sy_q) + SumBits'(s4_sz_q);
      sq_q[0].root <= '0;
    end
  end

  for (genvar i = 0; i < RootBits; i++) begin : g_sqrt
    localparam int Bit = RootBits - 1 - i;
    logic [SumBits-1:0] trial;
    hnm_sqrt_t          step_d;

    // Try to set this root bit against the running remainder.
    always_comb begin
      trial  = (SumBits'(sq_q[i].root) << (Bit + 1)) + (SumBits'(1) << (2 * Bit));
      step_d = sq_q[i];
      if (sq_q[i].rem >= trial) begin
        step_d.rem       = sq_q[i].rem - trial;
        step_d.root[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i+1] <= step_d;
      end
    end
  end

  // Encode stage: numerators (L +/- m) * 255 and the divisor 2L.
  logic [NumBits-1:0]  len_ext, num_x, num_y, num_z;
  logic [DivSteps-1:0] dv_v_q;
  hnm_div_t            dv_q [DivSteps];

  always_comb begin
    len_ext = NumBits'(sq_q[RootBits].root);
    num_x   = sq_q[RootBits].vec.nx ? len_ext - NumBits'(sq_q[RootBits].vec.mx)
                                    : len_ext + NumBits'(sq_q[RootBits].vec.mx);
    num_y   = sq_q[RootBits].vec.ny ? len_ext - NumBits'(sq_q[RootBits].vec.my)
                                    : len_ext + NumBits'(sq_q[RootBits].vec.my);
    num_z   = len_ext + NumBits'(sq_q[RootBits].vec.mz);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].land   <= sq_q[RootBits].vec.land;
      dv_q[0].rem[0] <= ProdBits'(num_x) * ProdBits'(ENC_SCALE);
      dv_q[0].rem[1] <= ProdBits'(num_y) * ProdBits'(ENC_SCALE);
      dv_q[0].rem[2] <= ProdBits'(num_z) * ProdBits'(ENC_SCALE);
      dv_q[0].quo    <= '0;
      dv_q[0].den    <= {sq_q[RootBits].root, 1'b0};
    end
  end

  // Restoring division, one quotient bit per stage for all three lanes.
  hnm_div_t dv_d [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Bit = DivSteps - 1 - j;
    logic [ProdBits-1:0] den_sh;

    always_comb begin
      den_sh  = ProdBits'(dv_q[j].den) << Bit;
      dv_d[j] = dv_q[j];
      for (int l = 0; l < 3; l++) begin
        if (dv_q[j].rem[l] >= den_sh) begin
          dv_d[j].rem[l]      = dv_q[j].rem[l] - den_sh;
          dv_d[j].quo[l][Bit] = 1'b1;
        end
      end
    end

    if (j < DivSteps - 1) begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_q[j+1] <= dv_d[j];
        end
      end
    end
  end

  // The encode stage takes its valid bit from the last root stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q <= '0;
    end else if (en) begin
      dv_v_q <= {dv_v_q[DivSteps-2:0], sq_v_q[RootBits]};
    end
  end

  // Output register: water pixels take the flat normal.
  logic       is_land_q;
  logic [7:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      is_land_q <= dv_d[DivSteps-1].land;
      red_q     <= dv_d[DivSteps-1].land ? dv_d[DivSteps-1].quo[0] : WATER_RED;
      green_q   <= dv_d[DivSteps-1].land ? dv_d[DivSteps-1].quo[1] : WATER_GREEN;
      blue_q    <= dv_d[DivSteps-1].land ? dv_d[DivSteps-1].quo[2] : WATER_BLUE;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_land_o      = is_land_q;
  assign normal_red_o   = red_q;
  assign normal_green_o = green_q;
  assign normal_blue_o  = blue_q;

endmodule

`default_nettype wire

// ===== sv/hnm_checker.sv =====
// ----------------------------------------------------------------------------
// hnm_checker
// Port-level checks on the height-to-normal-map pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "height_to_normal_map_pixel_top_assert.svh"

module hnm_checker import hnm_pkg::*; (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_stall_o,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire                          is_land_o,
  input wire [7:0]                    normal_red_o,
  input wire [7:0]                    normal_green_o,
  input wire [7:0]                    normal_blue_o
);

  // A held result stays on the port unchanged.
  `HNM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(is_land_o) && $stable(normal_red_o) &&
                   $stable(normal_green_o) && $stable(normal_blue_o))

  // Input is only held back while a finished item waits.
  `HNM_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // Water pixels carry the flat normal.
  `HNM_ASSERT_NOW(a_water_flat, out_valid_o && !is_land_o,
                  normal_red_o == WATER_RED && normal_green_o == WATER_GREEN &&
                  normal_blue_o == WATER_BLUE)

  // A land normal always points up, so blue sits in the upper half.
  `HNM_ASSERT_NOW(a_land_up, out_valid_o && is_land_o, normal_blue_o >= 8'd127)

endmodule

bind height_to_normal_map_pixel_top hnm_checker u_hnm_checker (.*);

`default_nettype wire
